/* sv/checked_counter_delta_merge_macros.svh */
// Assertion macros for the checked counter delta merge block.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef CHECKED_COUNTER_DELTA_MERGE_MACROS_SVH
`define CHECKED_COUNTER_DELTA_MERGE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define CCDM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define CCDM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ccdm_pkg.sv */
// Shared types and constants for the checked counter delta merge block.
// No dependencies; imported by checked_counter_delta_merge.
`default_nettype none

package ccdm_pkg;

    // Command codes
    localparam logic [1:0] CMD_SET_ADD   = 2'd0;
    localparam logic [1:0] CMD_ASSET_ADD = 2'd1;
    localparam logic [1:0] CMD_DELETE    = 2'd2;

    // Object kind codes
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_COUNTER = 2'd1;
    localparam logic [1:0] KIND_ASSET   = 2'd2;

    localparam logic signed [63:0] SIGNED_CEILING = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [63:0] base_value;
        logic signed [63:0] change;
        logic [63:0]        priority_req;
    } ccdm_req_t;

    typedef struct packed {
        logic               accepted;
        logic               obj_deleted;
        logic [1:0]         object_kind;
        logic signed [63:0] counter_value;
        logic signed [63:0] counter_sum;
        logic [63:0]        asset_amount;
        logic signed [63:0] asset_sum;
        logic [63:0]        counter_priority;
        logic [63:0]        asset_priority_out;
    } ccdm_rsp_t;

endpackage

`default_nettype wire

/* sv/checked_counter_delta_merge.sv */
// Update merger for one stored object (counter or asset) with checked adds.
// Depends on ccdm_pkg and checked_counter_delta_merge_macros.svh.
`default_nettype none

// One request is taken every cycle while req_stall is low. An accepted
// request lands in an input register; once the output register is free or
// its response is taken, one pass of merge logic (base check, three chained
// 64-bit signed adds with overflow tests, a 66-bit asset add and the priority
// compares) updates the object state and loads the response into an output
// register, which offers it until it is taken. The state feedback through
// that merge logic sets the rate of one request per cycle. A stalled response
// holds the merge stage, and the input register then raises stall.
module checked_counter_delta_merge (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    req_valid,
    output logic                   req_stall,
    input  ccdm_pkg::ccdm_req_t    req,
    output logic                   rsp_valid,
    input  wire                    rsp_stall,
    output ccdm_pkg::ccdm_rsp_t    rsp
);
    import ccdm_pkg::*;

    `include "checked_counter_delta_merge_macros.svh"

    // Pipeline registers
    logic      in_valid_reg, in_valid_next;
    ccdm_req_t in_reg;
    logic      out_valid_reg, out_valid_next;
    ccdm_rsp_t out_reg, out_next;

    // Object state
    logic [1:0]         kind_reg, kind_next;
    logic               deleted_reg, deleted_next;
    logic               have_base_reg, have_base_next;
    logic signed [63:0] base_reg, base_next;
    logic signed [63:0] sum_reg, sum_next;
    logic signed [63:0] counter_reg, counter_next;
    logic [63:0]        amount_reg, amount_next;
    logic               have_asum_reg, have_asum_next;
    logic signed [63:0] asum_reg, asum_next;
    logic [63:0]        cnt_prio_reg, cnt_prio_next;
    logic [63:0]        ast_prio_reg, ast_prio_next;

    logic advance;
    logic take;

    // Set-add datapath
    logic signed [63:0] old_sum, t_sum, bt_sum, nd_sum, cnt_sum;
    logic               base_ok, ovf_t, ovf_bt, ovf_cnt, set_ok;

    // Asset datapath
    logic [63:0]        amt_eff;
    logic [65:0]        amt_wide;
    logic signed [63:0] asum_add;
    logic               ovf_asum, asset_ok;

    logic ok;

    // Handshake: merge when a request waits and the response slot frees up
    assign advance   = in_valid_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall = in_valid_reg && !advance;
    assign take      = req_valid && !req_stall;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // Set-add: check base, merge change, form counter value
    always_comb
    begin
        old_sum = have_base_reg ? sum_reg : 64'sd0;
        base_ok = !have_base_reg || (base_reg == in_reg.base_value);
        t_sum   = in_reg.change + old_sum;
        ovf_t   = (in_reg.change[63] == old_sum[63]) && (t_sum[63] != old_sum[63]);
        bt_sum  = in_reg.base_value + t_sum;
        ovf_bt  = (in_reg.base_value[63] == t_sum[63])
                  && (bt_sum[63] != t_sum[63]);
        if (in_reg.change[63])
        begin
            nd_sum = t_sum;
            if (ovf_t)
                set_ok = 1'b0;
            else if (ovf_bt)
                set_ok = !in_reg.base_value[63];
            else
                set_ok = !bt_sum[63];
        end
        else
        begin
            nd_sum = ovf_t ? SIGNED_CEILING : t_sum;
            set_ok = 1'b1;
        end
        set_ok  = set_ok && base_ok;
        cnt_sum = in_reg.base_value + nd_sum;
        ovf_cnt = (in_reg.base_value[63] == nd_sum[63])
                  && (cnt_sum[63] != nd_sum[63]);
    end

    // Asset add: amount must stay in unsigned range, total in signed range
    always_comb
    begin
        amt_eff  = (kind_reg == KIND_NONE) ? 64'd0 : amount_reg;
        amt_wide = {2'b00, amt_eff} + {{2{in_reg.change[63]}}, in_reg.change};
        asum_add = asum_reg + in_reg.change;
        ovf_asum = have_asum_reg && (asum_reg[63] == in_reg.change[63])
                   && (asum_add[63] != asum_reg[63]);
        asset_ok = !ovf_asum && (amt_wide[65:64] == 2'b00);
    end

    // Next state and response
    always_comb
    begin
        kind_next      = kind_reg;
        deleted_next   = deleted_reg;
        have_base_next = have_base_reg;
        base_next      = base_reg;
        sum_next       = sum_reg;
        counter_next   = counter_reg;
        amount_next    = amount_reg;
        have_asum_next = have_asum_reg;
        asum_next      = asum_reg;
        cnt_prio_next  = cnt_prio_reg;
        ast_prio_next  = ast_prio_reg;
        ok             = 1'b0;

        priority if (in_reg.command == CMD_DELETE)
        begin
            deleted_next = 1'b1;
            kind_next    = KIND_NONE;
            counter_next = 64'sd0;
            amount_next  = 64'd0;
            ok           = 1'b1;
        end
        else if (!deleted_reg && in_reg.command == CMD_SET_ADD)
        begin
            if ((kind_reg == KIND_NONE || kind_reg == KIND_COUNTER) && set_ok)
            begin
                ok             = 1'b1;
                have_base_next = 1'b1;
                base_next      = in_reg.base_value;
                sum_next       = nd_sum;
                kind_next      = KIND_COUNTER;
                counter_next   = ovf_cnt ? SIGNED_CEILING : cnt_sum;
                if (in_reg.priority_req < cnt_prio_reg)
                    cnt_prio_next = in_reg.priority_req;
            end
        end
        else if (!deleted_reg && in_reg.command == CMD_ASSET_ADD)
        begin
            if (kind_reg == KIND_NONE || kind_reg == KIND_ASSET)
            begin
                // A rejected add still creates the asset object
                kind_next   = KIND_ASSET;
                amount_next = amt_eff;
                if (asset_ok)
                begin
                    ok             = 1'b1;
                    amount_next    = amt_wide[63:0];
                    asum_next      = have_asum_reg ? asum_add : in_reg.change;
                    have_asum_next = 1'b1;
                    if (in_reg.priority_req < ast_prio_reg)
                        ast_prio_next = in_reg.priority_req;
                end
            end
        end
        else
        begin
            // Reject an unknown code or any update of a deleted object
            ok = 1'b0;
        end

        out_next.accepted           = ok;
        out_next.obj_deleted        = deleted_next;
        out_next.object_kind        = kind_next;
        out_next.counter_value      = (kind_next == KIND_COUNTER) ? counter_next : 64'sd0;
        out_next.counter_sum        = sum_next;
        out_next.asset_amount       = (kind_next == KIND_ASSET) ? amount_next : 64'd0;
        out_next.asset_sum          = asum_next;
        out_next.counter_priority   = cnt_prio_next;
        out_next.asset_priority_out = ast_prio_next;
    end

    // Valid flags of the two register stages
    always_comb
    begin
        in_valid_next  = take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : ((out_valid_reg && !rsp_stall) ? 1'b0 : out_valid_reg);
    end

    // Hold control and object state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_NONE;
            deleted_reg   <= 1'b0;
            have_base_reg <= 1'b0;
            base_reg      <= '0;
            sum_reg       <= '0;
            counter_reg   <= '0;
            amount_reg    <= '0;
            have_asum_reg <= 1'b0;
            asum_reg      <= '0;
            cnt_prio_reg  <= '1;
            ast_prio_reg  <= '1;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                kind_reg      <= kind_next;
                deleted_reg   <= deleted_next;
                have_base_reg <= have_base_next;
                base_reg      <= base_next;
                sum_reg       <= sum_next;
                counter_reg   <= counter_next;
                amount_reg    <= amount_next;
                have_asum_reg <= have_asum_next;
                asum_reg      <= asum_next;
                cnt_prio_reg  <= cnt_prio_next;
                ast_prio_reg  <= ast_prio_next;
            end
        end
    end

    // Capture request and response payloads
    always_ff @(posedge clk)
    begin
        if (take)
            in_reg <= req;
        if (advance)
            out_reg <= out_next;
    end

    `CCDM_ASSERT_NEXT(a_deleted_sticky, deleted_reg, deleted_reg,
        "deleted flag cleared")
    `CCDM_ASSERT_SAME(a_deleted_no_kind, rsp_valid && rsp.obj_deleted,
        rsp.object_kind == KIND_NONE, "deleted object reports a kind")
    `CCDM_ASSERT_NEXT(a_counter_kind, kind_reg == KIND_COUNTER,
        kind_reg == KIND_COUNTER || kind_reg == KIND_NONE,
        "counter object changed to asset")
    `CCDM_ASSERT_NEXT(a_merge_to_rsp, advance, rsp_valid,
        "merged request produced no response")
    `CCDM_ASSERT_NEXT(a_prio_monotonic, 1'b1, cnt_prio_reg <= $past(cnt_prio_reg),
        "counter priority increased")

endmodule

`default_nettype wire
